// File: rtl/bmv_pkg.sv
// Shared widths and limits for the tile mean and variance block.
`timescale 1ns / 1ps
`default_nettype none

package bmv_pkg;

  // Largest number of pixels counted in one tile
  localparam int MAX_PIXELS = 262144;

  localparam int PIX_W   = 8;
  localparam int CNT_W   = 19;  // holds MAX_PIXELS itself
  localparam int SUM_W   = 26;
  localparam int SQ_W    = 34;
  localparam int ACC_W   = 53;  // n * sum of squares
  localparam int DEN_W   = 37;  // n * n
  localparam int REM_W   = 36;  // division remainder, always below n * n
  localparam int MEAN_W  = 16;
  localparam int VAR_W   = 22;
  localparam int FRAC_W  = 8;
  localparam int STEP_W  = 5;

endpackage

`default_nettype wire

// File: rtl/block_mean_variance_unit.sv
// Tile mean and population variance with one shared add/subtract unit.
//
// Pixels enter on the pixel channel (pixel, last, pixel_valid, pixel_stall)
// one per cycle, in raster order, while the block accumulates. The pixel
// marked last closes the tile: the block then raises pixel_stall and runs a
// sequencer over a single 53-bit adder/subtractor: three shift-add
// multiplies (n*sumsq, sum*sum, n*n), one subtract and two restoring
// divisions (16 and 22 quotient bits). result_valid rises once that
// sequence ends and the output register is free.
// The result (mean_fixed, variance_fixed, pixel_count, overflow) sits in
// an output register until result_stall is low. Pixels of the next tile
// are taken while it waits; if a second tile closes before the first
// result is taken, the block holds in its final step until the register
// frees. Pixels past MAX_PIXELS are dropped and flag overflow.
// rst (synchronous, active high) clears the running totals, the sequencer
// and result_valid.
`timescale 1ns / 1ps
`default_nettype none

module block_mean_variance_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [bmv_pkg::PIX_W-1:0]   pixel,
  input  wire logic                        last,
  input  wire logic                        pixel_valid,
  output logic                             pixel_stall,
  output logic [bmv_pkg::MEAN_W-1:0]       mean_fixed,
  output logic [bmv_pkg::VAR_W-1:0]        variance_fixed,
  output logic [bmv_pkg::CNT_W-1:0]        pixel_count,
  output logic                             overflow,
  output logic                             result_valid,
  input  wire logic                        result_stall
);

  import bmv_pkg::*;

  localparam logic [3:0] T_ACCUM  = 4'd0;
  localparam logic [3:0] T_LOAD   = 4'd1;
  localparam logic [3:0] T_MUL_NS = 4'd2;
  localparam logic [3:0] T_MUL_SS = 4'd3;
  localparam logic [3:0] T_SUB    = 4'd4;
  localparam logic [3:0] T_DIV_M  = 4'd5;
  localparam logic [3:0] T_MUL_NN = 4'd6;
  localparam logic [3:0] T_DIV_V  = 4'd7;
  localparam logic [3:0] T_DONE   = 4'd8;

  logic [3:0]              state;
  logic [STEP_W-1:0]       step;

  logic [CNT_W-1:0]        running_count;
  logic [SUM_W-1:0]        running_sum;
  logic [SQ_W-1:0]         running_square_sum;
  logic                    overflow_seen;

  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        mcand;
  logic [SUM_W-1:0]        mplier;
  logic [ACC_W-1:0]        dval;
  logic [DEN_W-1:0]        divisor;
  logic [REM_W-1:0]        rem;
  logic [VAR_W-1:0]        quo;
  logic [MEAN_W-1:0]       mean_res;

  logic [ACC_W-1:0]        alu_x;
  logic [ACC_W-1:0]        alu_y;
  logic                    alu_sub;
  logic [ACC_W:0]          alu_out;
  logic [DEN_W-1:0]        trial;
  logic                    qbit;

  logic                    pix_take;
  logic                    room;
  logic [2*PIX_W-1:0]      pix_sq;
  logic                    out_free;

  assign pixel_stall = (state != T_ACCUM);
  assign pix_take    = pixel_valid && !pixel_stall;
  assign room        = (running_count < CNT_W'(MAX_PIXELS));
  assign pix_sq      = pixel * pixel;
  assign out_free    = !result_valid || !result_stall;

  // Restoring division: bring in the next dividend bit from the top of quo
  assign trial = {rem, quo[VAR_W-1]};

  always_comb begin
    case (state)
      T_SUB: begin
        alu_x   = dval;
        alu_y   = acc;
        alu_sub = 1'b1;
      end
      T_DIV_M, T_DIV_V: begin
        alu_x   = {{(ACC_W-DEN_W){1'b0}}, trial};
        alu_y   = {{(ACC_W-DEN_W){1'b0}}, divisor};
        alu_sub = 1'b1;
      end
      default: begin
        alu_x   = acc;
        alu_y   = mplier[0] ? mcand : '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_out = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                 + {{ACC_W{1'b0}}, alu_sub};
  // Carry out of a subtract means no borrow
  assign qbit = alu_out[ACC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= T_ACCUM;
      step               <= '0;
      running_count      <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      overflow_seen      <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      // Raise on the final step, drop once the request is taken
      if (state == T_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        T_ACCUM: begin
          if (pix_take) begin
            if (room) begin
              running_count      <= running_count + CNT_W'(1);
              running_sum        <= running_sum + SUM_W'(pixel);
              running_square_sum <= running_square_sum + SQ_W'(pix_sq);
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last) begin
              state <= T_LOAD;
            end
          end
        end
        T_LOAD: begin
          acc    <= '0;
          mcand  <= {{(ACC_W-SQ_W){1'b0}}, running_square_sum};
          mplier <= {{(SUM_W-CNT_W){1'b0}}, running_count};
          step   <= STEP_W'(CNT_W-1);
          state  <= T_MUL_NS;
        end
        T_MUL_NS, T_MUL_SS, T_MUL_NN: begin
          acc    <= alu_out[ACC_W-1:0];
          mcand  <= {mcand[ACC_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[SUM_W-1:1]};
          step   <= step - STEP_W'(1);
          if (step == '0) begin
            if (state == T_MUL_NS) begin
              // Park n*sumsq and start sum*sum
              dval   <= alu_out[ACC_W-1:0];
              acc    <= '0;
              mcand  <= {{(ACC_W-SUM_W){1'b0}}, running_sum};
              mplier <= running_sum;
              step   <= STEP_W'(SUM_W-1);
              state  <= T_MUL_SS;
            end else if (state == T_MUL_SS) begin
              state <= T_SUB;
            end else begin
              // n*n is the variance divisor; the remainder starts at d / 2^14
              divisor <= alu_out[DEN_W-1:0];
              rem     <= dval[REM_W+VAR_W-FRAC_W-1:VAR_W-FRAC_W];
              quo     <= {dval[VAR_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
              step    <= STEP_W'(VAR_W-1);
              state   <= T_DIV_V;
            end
          end
        end
        T_SUB: begin
          dval    <= alu_out[ACC_W-1:0];
          // Mean: (sum << 8) / n, quotient known to fit 16 bits
          divisor <= {{(DEN_W-CNT_W){1'b0}}, running_count};
          rem     <= {{(REM_W-(SUM_W-FRAC_W)){1'b0}}, running_sum[SUM_W-1:FRAC_W]};
          quo     <= {running_sum[FRAC_W-1:0], {(VAR_W-FRAC_W){1'b0}}};
          step    <= STEP_W'(MEAN_W-1);
          state   <= T_DIV_M;
        end
        T_DIV_M, T_DIV_V: begin
          rem  <= qbit ? alu_out[REM_W-1:0] : trial[REM_W-1:0];
          quo  <= {quo[VAR_W-2:0], qbit};
          step <= step - STEP_W'(1);
          if (step == '0) begin
            if (state == T_DIV_M) begin
              mean_res <= {quo[MEAN_W-2:0], qbit};
              acc      <= '0;
              mcand    <= {{(ACC_W-CNT_W){1'b0}}, running_count};
              mplier   <= {{(SUM_W-CNT_W){1'b0}}, running_count};
              step     <= STEP_W'(CNT_W-1);
              state    <= T_MUL_NN;
            end else begin
              state <= T_DONE;
            end
          end
        end
        T_DONE: begin
          // Hold until the output register is free, then clear for the next tile
          if (out_free) begin
            state              <= T_ACCUM;
            running_count      <= '0;
            running_sum        <= '0;
            running_square_sum <= '0;
            overflow_seen      <= 1'b0;
          end
        end
        default: begin
          state <= T_ACCUM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_DONE && out_free) begin
      if (running_count == '0) begin
        mean_fixed     <= '0;
        variance_fixed <= '0;
      end else begin
        mean_fixed     <= mean_res;
        variance_fixed <= quo;
      end
      pixel_count <= running_count;
      overflow    <= overflow_seen;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    running_count <= CNT_W'(MAX_PIXELS))
    else $error("pixel count above limit");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    {2'b00, running_sum} <= ({1'b0, running_count, {FRAC_W{1'b0}}}
                             - {9'd0, running_count}))
    else $error("pixel sum exceeds 255 per counted pixel");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (running_count == CNT_W'(MAX_PIXELS)))
    else $error("overflow flagged before tile was full");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == T_DIV_V) |-> ({1'b0, rem} < divisor))
    else $error("division remainder not below divisor");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == T_DONE))
    else $error("result raised outside final step");

endmodule

`default_nettype wire

// File: dv/block_mean_variance_unit_tb.sv
// Self-checking bench for block_mean_variance_unit: streamed tiles, predicted tile statistics.
`timescale 1ns / 1ps

module block_mean_variance_unit_tb;
  import bmv_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 130;
  localparam int RANDOM_PIXELS = 600;
  localparam int RANDOM_TILES  = 30;

  typedef enum int {PIX_NOISE, PIX_FLAT, PIX_EXTREMES, PIX_NEAR} pixel_style_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic [CNT_W-1:0]  count;
    logic              ovf;
  } tile_stats_t;

  class tile_stats_board_t;
    longint unsigned tile_sum;
    longint unsigned tile_sq_sum;
    longint unsigned tile_count;
    bit              tile_dropped;
    tile_stats_t     pending[$];
    int              errors;

    function void note_pixel(logic [PIX_W-1:0] p, logic l);
      longint unsigned n2, d, q, r;
      tile_stats_t s;
      if (tile_count < MAX_PIXELS) begin
        tile_count++;
        tile_sum += p;
        tile_sq_sum += longint'(p) * longint'(p);
      end else begin
        tile_dropped = 1'b1;
      end
      if (!l) return;
      s = '0;
      if (tile_count != 0) begin
        // exact (n*sumsq - sum^2) / n^2, quotient and remainder scaled apart
        n2 = tile_count * tile_count;
        d = tile_count * tile_sq_sum - tile_sum * tile_sum;
        q = d / n2;
        r = d % n2;
        s.mean = MEAN_W'((tile_sum << FRAC_W) / tile_count);
        s.variance = VAR_W'((q << FRAC_W) + ((r << FRAC_W) / n2));
      end
      s.count = CNT_W'(tile_count);
      s.ovf = tile_dropped;
      pending.push_back(s);
      tile_sum = 0;
      tile_sq_sum = 0;
      tile_count = 0;
      tile_dropped = 1'b0;
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tile_stats_t got);
      tile_stats_t want;
      if (pending.size() == 0) begin
        $display("%0t: result expected none, got mean_fixed %0d variance_fixed %0d count %0d",
                 $time, got.mean, got.variance, got.count);
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("mean_fixed", want.mean, got.mean);
      check_field("variance_fixed", want.variance, got.variance);
      check_field("pixel_count", want.count, got.count);
      check_field("overflow", want.ovf, got.ovf);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [PIX_W-1:0]  pixel = '0;
  logic              last = 1'b0;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  logic [MEAN_W-1:0] mean_fixed;
  logic [VAR_W-1:0]  variance_fixed;
  logic [CNT_W-1:0]  pixel_count;
  logic              overflow;
  logic              result_valid;
  logic              result_stall = 1'b0;

  tile_stats_board_t board;
  int holds_asked = 0;
  int holds_done = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  block_mean_variance_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .pixel          (pixel),
    .last           (last),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .mean_fixed     (mean_fixed),
    .variance_fixed (variance_fixed),
    .pixel_count    (pixel_count),
    .overflow       (overflow),
    .result_valid   (result_valid),
    .result_stall   (result_stall)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("block_mean_variance_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      board.check_result({mean_fixed, variance_fixed, pixel_count, overflow});
  end

  // Result side: random stall stretches, plus a long hold whenever one is asked for
  initial begin : result_side
    int stretch;
    int pick;
    @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        result_stall <= 1'b1;
        stretch = LONG_HOLD;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          result_stall <= 1'b0;
          stretch = $urandom_range(1, 24);
        end else if (pick < 18) begin
          result_stall <= 1'b1;
          stretch = $urandom_range(1, 4);
        end else begin
          result_stall <= 1'b1;
          stretch = $urandom_range(10, 90);
        end
      end
      repeat (stretch) @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] p, input logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel <= p;
    last <= l;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall !== 1'b0);
    board.note_pixel(p, l);
  endtask

  // Drop valid and hold until every pending tile has reported
  task automatic drain_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  task automatic send_tile(input int len);
    pixel_style_t style;
    int base;
    int v;
    logic [PIX_W-1:0] p;
    style = pixel_style_t'($urandom_range(0, 3));
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (style)
        PIX_NOISE: p = PIX_W'($urandom_range(0, 255));
        PIX_FLAT: p = PIX_W'(base);
        PIX_EXTREMES: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: begin
          v = base + int'($urandom_range(0, 8)) - 4;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          p = PIX_W'(v);
        end
      endcase
      push_pixel(p, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int len;
    int tiles;
    int random_pixels;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single-pixel tiles at both ends of the range
    push_pixel(8'd0, 1'b1);
    push_pixel(8'd255, 1'b1);
    // half black, half white: largest variance
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd0, 1'b0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b0);
    push_pixel(8'd255, 1'b1);
    for (int b = 0; b < PIX_W; b++) push_pixel(8'd1 << b, 1'b0);
    push_pixel(8'd255, 1'b1);
    push_pixel(8'd170, 1'b0);
    push_pixel(8'd85, 1'b1);
    drain_results();

    tiles = 0;
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS || tiles < RANDOM_TILES) begin
      if (tiles == 12) holds_asked++;
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 8);
        len = len * len;
      end else begin
        len = $urandom_range(1, 24);
      end
      send_tile(len);
      random_pixels += len;
      tiles++;
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("block_mean_variance_unit verification clean");
    end else begin
      $display("block_mean_variance_unit verification failed");
    end
    $finish;
  end

endmodule
